@@ src/smct_pkg.sv @@
// Shared types and constants of the scanline mode change tracker.
// Holds the item, result and list entry types and the controller/datapath interface.
// No dependencies.
`default_nettype none

package smct_pkg;

	localparam int MaxChanges = 16;
	localparam int IdxW       = $clog2(MaxChanges);
	localparam int CntW       = $clog2(MaxChanges + 1);
	localparam int MaxResults = 17;
	localparam int ResCntW    = $clog2(MaxResults + 1);
	localparam int LineW      = 10;
	localparam int ModeW      = 8;
	localparam int PageW      = 4;
	localparam int HeightW    = 11;

	localparam logic [HeightW-1:0] FrameHeightReset = 11'd192;

	localparam logic KindSwitch   = 1'b0;
	localparam logic KindFrameEnd = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [LineW-1:0] line_number;
		logic [ModeW-1:0] mode_id;
		logic [PageW-1:0] page_number;
	} item_t;

	typedef struct packed {
		logic [HeightW-1:0] range_start;
		logic [HeightW-1:0] range_end;
		logic               has_range;
		logic               last_of_run;
	} result_t;

	typedef struct packed {
		logic [LineW-1:0] line_number;
		logic [ModeW-1:0] mode_id;
		logic [PageW-1:0] page_number;
	} entry_t;

	typedef struct packed {
		logic load;
		logic sw_read;
		logic sw_write;
		logic pc_dec;
		logic rd_first;
		logic walk_load;
		logic rd_next;
		logic walk_step;
		logic tail_sel;
		logic tail_push;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic pc_zero;
		logic trim;
		logic drop;
		logic walk_end;
		logic push_wait;
		logic out_free;
	} sts_t;

	function automatic logic differs(entry_t a, entry_t b);
		return (a.mode_id != b.mode_id) || (a.page_number != b.page_number);
	endfunction

endpackage

`default_nettype wire

@@ src/scanline_mode_change_tracker_core.sv @@
// Scanline mode change tracker: top level joining smct_ctrl and smct_dp.
// Depends on smct_pkg, smct_bank, smct_dp, smct_ctrl.
//
// Input channel item/item_valid/item_stall carries one beat per item. A mode
// switch edits the list of mode changes gathered for the frame; it produces no
// result. A frame end compares last frame's list with the gathered one and
// sends one result beat per dirty scanline range on result/result_valid/
// result_stall, the final beat marked last_of_run; a frame with no change sends
// a single beat with has_range low.
// The block works on one item at a time; item_stall is high while it is busy.
// A switch first removes tail entries at or past its line. A frame end walks
// both lists in line order and waits on a stalled receiver. Each merge step is
// one list bank read with registered data, then the compare. The first result
// appears after the walk has found the following one, or at its end. A stalled
// result holds in the output register, the next range in the hold register;
// the walk pauses when a further range is ready, and the frame end closes once
// the output register is free. The user writes frame_height through cfg_we and
// cfg_wdata only while idle; the block does not enforce it. Reset leaves both
// lists with one entry (line 0, mode 0, page 0) and frame_height at 192.
`default_nettype none

module scanline_mode_change_tracker_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             item_valid,
	output logic                            item_stall,
	input  smct_pkg::item_t                 item,
	input  wire                             cfg_we,
	input  wire [smct_pkg::HeightW-1:0]     cfg_wdata,
	output logic                            result_valid,
	input  wire                             result_stall,
	output smct_pkg::result_t               result
);

	smct_pkg::cmd_t cmd;
	smct_pkg::sts_t sts;

	smct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_kind  (item.kind),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	smct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ src/smct_bank.sv @@
// One list bank: a MaxChanges-entry memory with registered read data.
// Entries never written read as the zero entry. Depends on smct_pkg.
`default_nettype none

module smct_bank (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         wr_en,
	input  wire [smct_pkg::IdxW-1:0]    wr_addr,
	input  smct_pkg::entry_t            wr_data,
	input  wire                         rd_en,
	input  wire [smct_pkg::IdxW-1:0]    rd_addr,
	output smct_pkg::entry_t            rd_data
);

	smct_pkg::entry_t                    mem_q [smct_pkg::MaxChanges];
	logic [smct_pkg::MaxChanges-1:0]     vld_q;
	smct_pkg::entry_t                    rd_mem_q;
	logic                                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

`default_nettype wire

@@ src/smct_dp.sv @@
// Datapath: two list banks, counts, merge-walk registers, range hold and output beat register.
// Driven by smct_ctrl through cmd_t, reports through sts_t. Depends on smct_pkg, smct_bank.
`default_nettype none

module smct_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  smct_pkg::item_t                  item,
	input  wire                              cfg_we,
	input  wire [smct_pkg::HeightW-1:0]      cfg_wdata,
	input  smct_pkg::cmd_t                   cmd,
	output smct_pkg::sts_t                   sts,
	output logic                             result_valid,
	input  wire                              result_stall,
	output smct_pkg::result_t                result
);

	localparam int IdxW    = smct_pkg::IdxW;
	localparam int CntW    = smct_pkg::CntW;
	localparam int LineW   = smct_pkg::LineW;
	localparam int HeightW = smct_pkg::HeightW;
	localparam int ResCntW = smct_pkg::ResCntW;

	smct_pkg::item_t       item_q;
	logic [HeightW-1:0]    fh_q;
	logic                  cur_sel_q;
	logic [CntW-1:0]       cc_q;
	logic [CntW-1:0]       pc_q;
	logic [IdxW-1:0]       ic_q;
	logic [IdxW-1:0]       ip_q;
	smct_pkg::entry_t      cur_e_q;
	smct_pkg::entry_t      pen_e_q;
	logic                  diff_q;
	logic [LineW-1:0]      start_q;
	logic [HeightW-1:0]    hold_s_q;
	logic [HeightW-1:0]    hold_e_q;
	logic                  hold_v_q;
	logic [ResCntW-1:0]    n_q;
	logic                  out_valid_q;
	smct_pkg::result_t     out_q;

	logic [1:0]            b_wr_en;
	logic [1:0]            b_rd_en;
	logic [IdxW-1:0]       b_wr_addr [2];
	logic [IdxW-1:0]       b_rd_addr [2];
	smct_pkg::entry_t      b_wr_data [2];
	smct_pkg::entry_t      b_rd_data [2];

	smct_pkg::entry_t      rd_cur;
	smct_pkg::entry_t      rd_pend;
	logic [IdxW-1:0]       pend_raddr;
	logic [IdxW-1:0]       cur_raddr;
	logic [CntW-1:0]       pc_m1;
	logic [CntW-1:0]       ic_inc;
	logic [CntW-1:0]       ip_inc;
	logic                  cur_end;
	logic                  pen_end;
	logic                  adv_cur;
	smct_pkg::entry_t      nxt_cur;
	smct_pkg::entry_t      nxt_pen;
	logic [LineW-1:0]      at_line;
	logic                  diff2;
	logic                  want;
	logic [HeightW-1:0]    cand_end;
	logic [HeightW-1:0]    clip_end;
	logic [HeightW-1:0]    r_start;
	logic                  produce;
	logic                  out_free;
	logic                  do_push;

	assign pc_m1  = pc_q - CntW'(1);
	assign ic_inc = CntW'(ic_q) + CntW'(1);
	assign ip_inc = CntW'(ip_q) + CntW'(1);

	assign pend_raddr = cmd.sw_read ? pc_m1[IdxW-1:0] :
	                    (cmd.rd_next ? ip_inc[IdxW-1:0] : '0);
	assign cur_raddr  = cmd.rd_next ? ic_inc[IdxW-1:0] : '0;

	genvar g;
	for (g = 0; g < 2; g++) begin : g_bank
		logic is_cur;

		assign is_cur       = (cur_sel_q == 1'(g));
		assign b_rd_en[g]   = is_cur ? (cmd.rd_first | cmd.rd_next)
		                             : (cmd.sw_read | cmd.rd_first | cmd.rd_next);
		assign b_rd_addr[g] = is_cur ? cur_raddr : pend_raddr;
		assign b_wr_en[g]   = is_cur ? cmd.flush : cmd.sw_write;
		assign b_wr_addr[g] = is_cur ? '0 : pc_q[IdxW-1:0];
		assign b_wr_data[g] = is_cur ?
			smct_pkg::entry_t'{line_number: '0, mode_id: pen_e_q.mode_id,
			                   page_number: pen_e_q.page_number} :
			smct_pkg::entry_t'{line_number: item_q.line_number, mode_id: item_q.mode_id,
			                   page_number: item_q.page_number};

		smct_bank u_bank (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (b_wr_en[g]),
			.wr_addr (b_wr_addr[g]),
			.wr_data (b_wr_data[g]),
			.rd_en   (b_rd_en[g]),
			.rd_addr (b_rd_addr[g]),
			.rd_data (b_rd_data[g])
		);
	end

	assign rd_cur  = b_rd_data[cur_sel_q];
	assign rd_pend = b_rd_data[~cur_sel_q];

	// merge step
	assign cur_end  = ic_inc >= cc_q;
	assign pen_end  = ip_inc >= pc_q;
	assign adv_cur  = pen_end || (!cur_end && (rd_cur.line_number < rd_pend.line_number));
	assign nxt_cur  = adv_cur ? rd_cur : cur_e_q;
	assign nxt_pen  = adv_cur ? pen_e_q : rd_pend;
	assign at_line  = adv_cur ? rd_cur.line_number : rd_pend.line_number;
	assign diff2    = smct_pkg::differs(nxt_cur, nxt_pen);

	// candidate range, clipped to the frame
	assign want     = cmd.tail_sel ? diff_q : (diff_q && !diff2);
	assign cand_end = cmd.tail_sel ? fh_q : HeightW'(at_line);
	assign clip_end = (cand_end > fh_q) ? fh_q : cand_end;
	assign r_start  = HeightW'(start_q);
	assign produce  = want && (r_start < clip_end) && (n_q < ResCntW'(smct_pkg::MaxResults));

	assign out_free = !out_valid_q || !result_stall;
	assign do_push  = (cmd.walk_step || cmd.tail_push) && produce;

	assign sts.pc_zero   = (pc_q == '0);
	assign sts.trim      = rd_pend.line_number >= item_q.line_number;
	assign sts.drop      = (pc_q >= CntW'(smct_pkg::MaxChanges)) ||
	                       ((rd_pend.mode_id == item_q.mode_id) &&
	                        (rd_pend.page_number == item_q.page_number));
	assign sts.walk_end  = cur_end && pen_end;
	assign sts.push_wait = produce && hold_v_q && !out_free;
	assign sts.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.walk_load) begin
			cur_e_q <= rd_cur;
			pen_e_q <= rd_pend;
		end else if (cmd.walk_step) begin
			cur_e_q <= nxt_cur;
			pen_e_q <= nxt_pen;
		end
		if (do_push) begin
			hold_s_q <= r_start;
			hold_e_q <= clip_end;
		end
		if (cmd.flush) begin
			out_q <= hold_v_q ?
				smct_pkg::result_t'{range_start: hold_s_q, range_end: hold_e_q,
				                    has_range: 1'b1, last_of_run: 1'b1} :
				smct_pkg::result_t'{range_start: '0, range_end: '0,
				                    has_range: 1'b0, last_of_run: 1'b1};
		end else if (do_push && hold_v_q) begin
			out_q <= smct_pkg::result_t'{range_start: hold_s_q, range_end: hold_e_q,
			                             has_range: 1'b1, last_of_run: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q        <= smct_pkg::FrameHeightReset;
			cur_sel_q   <= 1'b0;
			cc_q        <= CntW'(1);
			pc_q        <= CntW'(1);
			ic_q        <= '0;
			ip_q        <= '0;
			diff_q      <= 1'b0;
			start_q     <= '0;
			hold_v_q    <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fh_q <= cfg_wdata;
			end

			// pending count and bank swap
			if (cmd.flush) begin
				pc_q      <= CntW'(1);
				cc_q      <= pc_q;
				cur_sel_q <= ~cur_sel_q;
			end else if (cmd.pc_dec) begin
				pc_q <= pc_m1;
			end else if (cmd.sw_write) begin
				pc_q <= pc_q + CntW'(1);
			end

			// walk position
			if (cmd.walk_load) begin
				ic_q    <= '0;
				ip_q    <= '0;
				diff_q  <= smct_pkg::differs(rd_cur, rd_pend);
				start_q <= '0;
			end else if (cmd.walk_step) begin
				if (adv_cur) begin
					ic_q <= ic_inc[IdxW-1:0];
				end else begin
					ip_q <= ip_inc[IdxW-1:0];
				end
				diff_q <= diff2;
				if (!diff_q && diff2) begin
					start_q <= at_line;
				end
			end

			// range hold
			if (cmd.flush) begin
				hold_v_q <= 1'b0;
				n_q      <= '0;
			end else if (do_push) begin
				hold_v_q <= 1'b1;
				n_q      <= n_q + ResCntW'(1);
			end

			// output beat
			if (cmd.flush || (do_push && hold_v_q)) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= CntW'(smct_pkg::MaxChanges))
		else $error("pending count above list depth");

	a_cc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cc_q != '0) && (cc_q <= CntW'(smct_pkg::MaxChanges)))
		else $error("current count out of range");

	a_hold_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (n_q != '0))
		else $error("held range without a counted result");

	a_flush_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> out_free)
		else $error("frame end closed while output beat blocked");

endmodule

`default_nettype wire

@@ src/smct_ctrl.sv @@
// Controller state machine of the tracker: sequences switch edits and the frame end walk.
// Talks to smct_dp through cmd_t and sts_t. Depends on smct_pkg.
`default_nettype none

module smct_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	input  wire                 item_kind,
	output logic                item_stall,
	output smct_pkg::cmd_t      cmd,
	input  smct_pkg::sts_t      sts
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SW_RD    = 9'b000000010,
		S_SW_CMP   = 9'b000000100,
		S_FE_RD0   = 9'b000001000,
		S_FE_LD0   = 9'b000010000,
		S_FE_RD    = 9'b000100000,
		S_FE_STEP  = 9'b001000000,
		S_FE_TAIL  = 9'b010000000,
		S_FE_FLUSH = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = (item_kind == smct_pkg::KindFrameEnd) ? S_FE_RD0 : S_SW_RD;
				end
			end
			S_SW_RD: begin
				if (sts.pc_zero) begin
					cmd.sw_write = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.sw_read = 1'b1;
					state_d     = S_SW_CMP;
				end
			end
			S_SW_CMP: begin
				if (sts.trim) begin
					cmd.pc_dec = 1'b1;
					state_d    = S_SW_RD;
				end else begin
					cmd.sw_write = !sts.drop;
					state_d      = S_IDLE;
				end
			end
			S_FE_RD0: begin
				cmd.rd_first = 1'b1;
				state_d      = S_FE_LD0;
			end
			S_FE_LD0: begin
				cmd.walk_load = 1'b1;
				state_d       = S_FE_RD;
			end
			S_FE_RD: begin
				if (sts.walk_end) begin
					state_d = S_FE_TAIL;
				end else begin
					cmd.rd_next = 1'b1;
					state_d     = S_FE_STEP;
				end
			end
			S_FE_STEP: begin
				if (!sts.push_wait) begin
					cmd.walk_step = 1'b1;
					state_d       = S_FE_RD;
				end
			end
			S_FE_TAIL: begin
				cmd.tail_sel = 1'b1;
				if (!sts.push_wait) begin
					cmd.tail_push = 1'b1;
					state_d       = S_FE_FLUSH;
				end
			end
			S_FE_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire
